// ----- sv/ctc_pkg.sv -----
// ctc_pkg: shared types and constants of the climate tick controller
// no dependencies; every other file of the block uses it by scoped names
`default_nettype none

package ctc_pkg;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_TEMP_LIMITS     = 3'd0,
      CSR_HUMI_LIMITS     = 3'd1,
      CSR_SPRAY_ON_TICKS  = 3'd2,
      CSR_SPRAY_OFF_TICKS = 3'd3,
      CSR_SUNRISE_MINUTES = 3'd4,
      CSR_SUNSET_MINUTES  = 3'd5,
      CSR_BUZZER_ENABLE   = 3'd6
   } csr_index_type;

   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   // tank level codes
   localparam logic [1:0] TANK_FULL = 2'd0;
   localparam logic [1:0] TANK_MID  = 2'd1;
   localparam logic [1:0] TANK_DRY  = 2'd2;

   // spray counter parked value and minutes per hour
   localparam logic [14:0] SPRAY_IDLE   = 15'h7FFF;
   localparam logic [5:0]  MIN_PER_HOUR = 6'd60;

   // one request as held in the input register
   typedef struct packed {
      logic              sensor_ok;
      logic signed [7:0] temperature;
      logic [6:0]        humidity;
      logic              water_high_pin;
      logic              water_low_pin;
      logic [4:0]        clock_hour;
      logic [5:0]        clock_minute;
   } req_type;

   // one result as held in the output register
   typedef struct packed {
      logic       heater_on;
      logic       sprayer_on;
      logic       daylight_on;
      logic [1:0] tank_state;
      logic       temp_low_flag;
      logic       temp_high_flag;
      logic       humi_low_flag;
      logic       humi_high_flag;
      logic       sensor_fault;
      logic       beep_start;
      logic       blink_phase;
   } rsp_type;

   // decoded configuration handed to the tick logic
   typedef struct packed {
      logic signed [7:0] temp_heat_on;
      logic signed [7:0] temp_heat_off;
      logic signed [7:0] temp_alarm_low;
      logic signed [7:0] temp_alarm_high;
      logic [7:0]        humi_spray_on;
      logic [7:0]        humi_spray_off;
      logic [7:0]        humi_alarm_low;
      logic [7:0]        humi_alarm_high;
      logic [14:0]       spray_on_ticks;
      logic [14:0]       spray_off_ticks;
      logic [10:0]       sunrise_minutes;
      logic [10:0]       sunset_minutes;
      logic              buzzer_enable;
   } cfg_type;

endpackage

`default_nettype wire

// ----- sv/ctc_if.sv -----
// ctc_if: valid/ready channels of the climate tick controller
// depends on ctc_pkg for the register index and data widths
`default_nettype none

// request channel: one control tick of sensor and clock readings
interface ctc_req_if;
   logic              valid;
   logic              ready;
   logic              sensor_ok;
   logic signed [7:0] temperature;
   logic [6:0]        humidity;
   logic              water_high_pin;
   logic              water_low_pin;
   logic [4:0]        clock_hour;
   logic [5:0]        clock_minute;

   modport source (
      output valid, sensor_ok, temperature, humidity, water_high_pin, water_low_pin,
             clock_hour, clock_minute,
      input  ready
   );
   modport sink (
      input  valid, sensor_ok, temperature, humidity, water_high_pin, water_low_pin,
             clock_hour, clock_minute,
      output ready
   );
endinterface

// result channel: actuator drives and alarm status of one tick
interface ctc_rsp_if;
   logic       valid;
   logic       ready;
   logic       heater_on;
   logic       sprayer_on;
   logic       daylight_on;
   logic [1:0] tank_state;
   logic       temp_low_flag;
   logic       temp_high_flag;
   logic       humi_low_flag;
   logic       humi_high_flag;
   logic       sensor_fault;
   logic       beep_start;
   logic       blink_phase;

   modport source (
      output valid, heater_on, sprayer_on, daylight_on, tank_state, temp_low_flag,
             temp_high_flag, humi_low_flag, humi_high_flag, sensor_fault, beep_start,
             blink_phase,
      input  ready
   );
   modport sink (
      input  valid, heater_on, sprayer_on, daylight_on, tank_state, temp_low_flag,
             temp_high_flag, humi_low_flag, humi_high_flag, sensor_fault, beep_start,
             blink_phase,
      output ready
   );
endinterface

// register write channel
interface ctc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ctc_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [ctc_pkg::CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- sv/climate_tick_controller.sv -----
// climate_tick_controller: top level, input register, result register and handshakes
// depends on ctc_pkg, ctc_if, ctc_csr_regs and ctc_tick_logic
//
//   channel   modport   direction   moves
//   req_chan  sink      in          one control tick of readings
//   rsp_chan  source    out         actuator drives and alarm flags
//   csr_chan  sink      in          register write (index, data)
//
// one request per cycle sustained while the result side keeps taking results
// the tick update is one pass of logic between the input and result registers
// synchronous active-high reset clears state, limits and both valid flags
// a stalled result holds while the input register still takes one more request
`default_nettype none

module climate_tick_controller #(
   parameter int unsigned ERROR_LIMIT  = 5,
   parameter int unsigned REPEAT_TICKS = 60,
   parameter int unsigned BLINK_TICKS  = 2
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ctc_req_if.sink    req_chan,
   ctc_rsp_if.source  rsp_chan,
   ctc_csr_if.sink    csr_chan
);

   ctc_pkg::req_type req_ff, req_in;
   logic             req_valid_ff, req_valid_in;
   ctc_pkg::rsp_type rsp_ff, rsp_in, rsp_next;
   logic             rsp_valid_ff, rsp_valid_in;
   ctc_pkg::cfg_type cfg;
   logic             advance;
   logic             req_take;

   // register writes are always taken
   assign csr_chan.ready = 1'b1;

   ctc_csr_regs u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_chan.valid),
      .wr_index (csr_chan.index),
      .wr_data  (csr_chan.data),
      .cfg      (cfg)
   );

   // move from input register to result register when the result slot frees
   assign advance          = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready   = !req_valid_ff || advance;
   assign req_take         = req_chan.valid && req_chan.ready;

   ctc_tick_logic #(
      .ERROR_LIMIT  (ERROR_LIMIT),
      .REPEAT_TICKS (REPEAT_TICKS),
      .BLINK_TICKS  (BLINK_TICKS)
   ) u_tick (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .req     (req_ff),
      .cfg     (cfg),
      .rsp     (rsp_next)
   );

   // input register
   always_comb begin
      req_in       = req_ff;
      req_valid_in = req_valid_ff && !advance;
      if (req_take) begin
         req_in.sensor_ok      = req_chan.sensor_ok;
         req_in.temperature    = req_chan.temperature;
         req_in.humidity       = req_chan.humidity;
         req_in.water_high_pin = req_chan.water_high_pin;
         req_in.water_low_pin  = req_chan.water_low_pin;
         req_in.clock_hour     = req_chan.clock_hour;
         req_in.clock_minute   = req_chan.clock_minute;
         req_valid_in          = 1'b1;
      end
   end

   // result register
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (advance) begin
         rsp_in       = rsp_next;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   // result port
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.heater_on      = rsp_ff.heater_on;
   assign rsp_chan.sprayer_on     = rsp_ff.sprayer_on;
   assign rsp_chan.daylight_on    = rsp_ff.daylight_on;
   assign rsp_chan.tank_state     = rsp_ff.tank_state;
   assign rsp_chan.temp_low_flag  = rsp_ff.temp_low_flag;
   assign rsp_chan.temp_high_flag = rsp_ff.temp_high_flag;
   assign rsp_chan.humi_low_flag  = rsp_ff.humi_low_flag;
   assign rsp_chan.humi_high_flag = rsp_ff.humi_high_flag;
   assign rsp_chan.sensor_fault   = rsp_ff.sensor_fault;
   assign rsp_chan.beep_start     = rsp_ff.beep_start;
   assign rsp_chan.blink_phase    = rsp_ff.blink_phase;

endmodule

`default_nettype wire

// ----- sv/ctc_csr_regs.sv -----
// ctc_csr_regs: configuration registers of the climate tick controller
// depends on ctc_pkg (index codes, cfg_type)
`default_nettype none

module ctc_csr_regs (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                wr_valid,
   input  wire logic [ctc_pkg::CSR_INDEX_WIDTH-1:0] wr_index,
   input  wire logic [ctc_pkg::CSR_DATA_WIDTH-1:0]  wr_data,
   output ctc_pkg::cfg_type                         cfg
);

   logic [31:0] temp_limits_ff, temp_limits_in;
   logic [31:0] humi_limits_ff, humi_limits_in;
   logic [14:0] spray_on_ff, spray_on_in;
   logic [14:0] spray_off_ff, spray_off_in;
   logic [10:0] sunrise_ff, sunrise_in;
   logic [10:0] sunset_ff, sunset_in;
   logic        buzzer_ff, buzzer_in;

   // write decode; unknown indexes are dropped
   always_comb begin
      temp_limits_in = temp_limits_ff;
      humi_limits_in = humi_limits_ff;
      spray_on_in    = spray_on_ff;
      spray_off_in   = spray_off_ff;
      sunrise_in     = sunrise_ff;
      sunset_in      = sunset_ff;
      buzzer_in      = buzzer_ff;
      if (wr_valid) begin
         unique case (ctc_pkg::csr_index_type'(wr_index))
            ctc_pkg::CSR_TEMP_LIMITS:     temp_limits_in = wr_data;
            ctc_pkg::CSR_HUMI_LIMITS:     humi_limits_in = wr_data;
            ctc_pkg::CSR_SPRAY_ON_TICKS:  spray_on_in    = wr_data[14:0];
            ctc_pkg::CSR_SPRAY_OFF_TICKS: spray_off_in   = wr_data[14:0];
            ctc_pkg::CSR_SUNRISE_MINUTES: sunrise_in     = wr_data[10:0];
            ctc_pkg::CSR_SUNSET_MINUTES:  sunset_in      = wr_data[10:0];
            ctc_pkg::CSR_BUZZER_ENABLE:   buzzer_in      = wr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_limits_ff <= '0;
         humi_limits_ff <= '0;
         spray_on_ff    <= '0;
         spray_off_ff   <= '0;
         sunrise_ff     <= '0;
         sunset_ff      <= '0;
         buzzer_ff      <= 1'b0;
      end else begin
         temp_limits_ff <= temp_limits_in;
         humi_limits_ff <= humi_limits_in;
         spray_on_ff    <= spray_on_in;
         spray_off_ff   <= spray_off_in;
         sunrise_ff     <= sunrise_in;
         sunset_ff      <= sunset_in;
         buzzer_ff      <= buzzer_in;
      end
   end

   // split the limit words into their bytes
   assign cfg.temp_heat_on    = $signed(temp_limits_ff[7:0]);
   assign cfg.temp_heat_off   = $signed(temp_limits_ff[15:8]);
   assign cfg.temp_alarm_low  = $signed(temp_limits_ff[23:16]);
   assign cfg.temp_alarm_high = $signed(temp_limits_ff[31:24]);
   assign cfg.humi_spray_on   = humi_limits_ff[7:0];
   assign cfg.humi_spray_off  = humi_limits_ff[15:8];
   assign cfg.humi_alarm_low  = humi_limits_ff[23:16];
   assign cfg.humi_alarm_high = humi_limits_ff[31:24];
   assign cfg.spray_on_ticks  = spray_on_ff;
   assign cfg.spray_off_ticks = spray_off_ff;
   assign cfg.sunrise_minutes = sunrise_ff;
   assign cfg.sunset_minutes  = sunset_ff;
   assign cfg.buzzer_enable   = buzzer_ff;

endmodule

`default_nettype wire

// ----- sv/ctc_tick_logic.sv -----
// ctc_tick_logic: controller state and the per-tick update of one request
// depends on ctc_pkg (req_type, rsp_type, cfg_type, codes)
`default_nettype none

module ctc_tick_logic #(
   parameter int unsigned ERROR_LIMIT  = 5,
   parameter int unsigned REPEAT_TICKS = 60,
   parameter int unsigned BLINK_TICKS  = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             advance,
   input  ctc_pkg::req_type      req,
   input  ctc_pkg::cfg_type      cfg,
   output ctc_pkg::rsp_type      rsp
);

   localparam logic [7:0]  ERR_MAX   = 8'(ERROR_LIMIT);
   localparam logic [15:0] REPEAT_MAX = 16'(REPEAT_TICKS);
   localparam logic [15:0] BLINK_MAX = 16'(BLINK_TICKS);

   logic        heater_ff, heater_in;
   logic        spray_en_ff, spray_en_in;
   logic        spray_ph_ff, spray_ph_in;
   logic [14:0] spray_cnt_ff, spray_cnt_in;
   logic [7:0]  err_cnt_ff, err_cnt_in;
   logic        fault_ff, fault_in;
   logic        sounding_ff, sounding_in;
   logic [15:0] repeat_ff, repeat_in;
   logic        blink_ff, blink_in;
   logic [15:0] blink_cnt_ff, blink_cnt_in;

   logic        t_lo, t_hi, h_lo, h_hi;
   logic        tank_alarm, daylight, beep, any_alarm;
   logic [1:0]  tank;
   logic [7:0]  err_inc;
   logic [7:0]  humi8;
   logic [10:0] now;
   logic [14:0] spray_step;

   assign humi8 = {1'b0, req.humidity};
   assign now   = 11'(req.clock_hour) * 11'(ctc_pkg::MIN_PER_HOUR) + 11'(req.clock_minute);

   // sensor fault tracking, saturating at the error limit
   always_comb begin
      err_inc    = err_cnt_ff + 8'd1;
      err_cnt_in = err_cnt_ff;
      fault_in   = fault_ff;
      if (!req.sensor_ok) begin
         err_cnt_in = err_inc;
         if (err_inc >= ERR_MAX) begin
            err_cnt_in = ERR_MAX;
            fault_in   = 1'b1;
         end
      end else begin
         err_cnt_in = '0;
         fault_in   = 1'b0;
      end
   end

   // heater hysteresis and temperature alarms
   always_comb begin
      heater_in = 1'b0;
      t_lo      = 1'b0;
      t_hi      = 1'b0;
      if (req.sensor_ok) begin
         heater_in = heater_ff;
         if (req.temperature <= cfg.temp_heat_on && !heater_ff) begin
            heater_in = 1'b1;
         end else if (req.temperature >= cfg.temp_heat_off && heater_ff) begin
            heater_in = 1'b0;
         end
         t_lo = req.temperature <= cfg.temp_alarm_low;
         t_hi = req.temperature >= cfg.temp_alarm_high;
      end
   end

   // tank level from the two sense pins
   always_comb begin
      tank_alarm = 1'b0;
      if (req.water_low_pin && req.water_high_pin) begin
         tank = ctc_pkg::TANK_FULL;
      end else if (req.water_low_pin) begin
         tank = ctc_pkg::TANK_MID;
      end else begin
         tank       = ctc_pkg::TANK_DRY;
         tank_alarm = 1'b1;
      end
   end

   // sprayer enable hysteresis and on/off duty cycle
   always_comb begin
      spray_en_in  = 1'b0;
      spray_ph_in  = 1'b0;
      spray_cnt_in = ctc_pkg::SPRAY_IDLE;
      spray_step   = ctc_pkg::SPRAY_IDLE;
      h_lo         = 1'b0;
      h_hi         = 1'b0;
      if (req.sensor_ok && !tank_alarm) begin
         spray_en_in  = spray_en_ff;
         spray_ph_in  = spray_ph_ff;
         spray_cnt_in = spray_cnt_ff;
         if (humi8 <= cfg.humi_spray_on && !spray_en_ff) begin
            spray_en_in = 1'b1;
         end else if (humi8 >= cfg.humi_spray_off && spray_en_ff) begin
            spray_en_in  = 1'b0;
            spray_ph_in  = 1'b0;
            spray_cnt_in = ctc_pkg::SPRAY_IDLE;
         end
         if (spray_en_in) begin
            spray_step   = (spray_cnt_in < ctc_pkg::SPRAY_IDLE) ? spray_cnt_in + 15'd1
                                                                : spray_cnt_in;
            spray_cnt_in = spray_step;
            if (spray_ph_in) begin
               if (spray_step >= cfg.spray_on_ticks) begin
                  spray_ph_in  = 1'b0;
                  spray_cnt_in = '0;
               end
            end else begin
               if (spray_step >= cfg.spray_off_ticks) begin
                  spray_ph_in  = 1'b1;
                  spray_cnt_in = '0;
               end
            end
         end
         h_lo = humi8 <= cfg.humi_alarm_low;
         h_hi = humi8 >= cfg.humi_alarm_high;
      end
   end

   // daylight window, wrapping past midnight when sunset precedes sunrise
   always_comb begin
      if (cfg.sunset_minutes >= cfg.sunrise_minutes) begin
         daylight = (now >= cfg.sunrise_minutes) && (now < cfg.sunset_minutes);
      end else begin
         daylight = !((now >= cfg.sunset_minutes) && (now < cfg.sunrise_minutes));
      end
   end

   // alarm beep re-arming and blink phase
   assign any_alarm = t_lo || t_hi || h_lo || h_hi || tank_alarm || fault_in;

   always_comb begin
      beep         = 1'b0;
      sounding_in  = sounding_ff;
      repeat_in    = repeat_ff;
      blink_in     = blink_ff;
      blink_cnt_in = blink_cnt_ff;
      if (any_alarm) begin
         if (!sounding_ff) begin
            beep        = cfg.buzzer_enable;
            sounding_in = 1'b1;
            repeat_in   = '0;
         end else begin
            repeat_in = repeat_ff + 16'd1;
            if (repeat_in >= REPEAT_MAX) begin
               sounding_in = 1'b0;
            end
         end
         blink_cnt_in = blink_cnt_ff + 16'd1;
         if (blink_cnt_in >= BLINK_MAX) begin
            blink_in     = !blink_ff;
            blink_cnt_in = '0;
         end
      end else begin
         sounding_in = 1'b0;
         repeat_in   = '0;
      end
   end

   // state advances once per request handed to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         heater_ff    <= 1'b0;
         spray_en_ff  <= 1'b0;
         spray_ph_ff  <= 1'b0;
         spray_cnt_ff <= ctc_pkg::SPRAY_IDLE;
         err_cnt_ff   <= '0;
         fault_ff     <= 1'b0;
         sounding_ff  <= 1'b0;
         repeat_ff    <= '0;
         blink_ff     <= 1'b1;
         blink_cnt_ff <= '0;
      end else if (advance) begin
         heater_ff    <= heater_in;
         spray_en_ff  <= spray_en_in;
         spray_ph_ff  <= spray_ph_in;
         spray_cnt_ff <= spray_cnt_in;
         err_cnt_ff   <= err_cnt_in;
         fault_ff     <= fault_in;
         sounding_ff  <= sounding_in;
         repeat_ff    <= repeat_in;
         blink_ff     <= blink_in;
         blink_cnt_ff <= blink_cnt_in;
      end
   end

   // result fields
   assign rsp.heater_on      = heater_in;
   assign rsp.sprayer_on     = spray_ph_in;
   assign rsp.daylight_on    = daylight;
   assign rsp.tank_state     = tank;
   assign rsp.temp_low_flag  = t_lo;
   assign rsp.temp_high_flag = t_hi;
   assign rsp.humi_low_flag  = h_lo;
   assign rsp.humi_high_flag = h_hi;
   assign rsp.sensor_fault   = fault_in;
   assign rsp.beep_start     = beep;
   assign rsp.blink_phase    = blink_in;

endmodule

`default_nettype wire

// ----- sv/ctc_checker.sv -----
// ctc_checker: port-level checks of the climate tick controller, bound to the top
// depends on ctc_pkg, climate_tick_controller and its channel interfaces
`default_nettype none

module ctc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic       heater_on,
   input wire logic       sprayer_on,
   input wire logic [1:0] tank_state,
   input wire logic       humi_low_flag,
   input wire logic       humi_high_flag,
   input wire logic       sensor_fault
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // nothing is offered straight after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered after reset");

   // a faulted sensor keeps heater and sprayer off
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && sensor_fault |-> !heater_on && !sprayer_on)
      else $error("actuator on with sensor fault");

   // an empty tank stops the sprayer and masks the humidity alarms
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && tank_state == ctc_pkg::TANK_DRY |->
         !sprayer_on && !humi_low_flag && !humi_high_flag)
      else $error("sprayer or humidity alarm with empty tank");

   // tank code is never the unused one
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> tank_state <= ctc_pkg::TANK_DRY)
      else $error("invalid tank code");

endmodule

bind climate_tick_controller ctc_checker u_ctc_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .heater_on      (rsp_chan.heater_on),
   .sprayer_on     (rsp_chan.sprayer_on),
   .tank_state     (rsp_chan.tank_state),
   .humi_low_flag  (rsp_chan.humi_low_flag),
   .humi_high_flag (rsp_chan.humi_high_flag),
   .sensor_fault   (rsp_chan.sensor_fault)
);

`default_nettype wire

// ----- test/testbench.sv -----
// testbench: self-checking bench for the climate tick controller, one request per tick
// depends on ctc_pkg and the channel interfaces in ctc_if; drives climate_tick_controller
// a tick predictor in this file produces the expected result of every accepted request

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned ERROR_LIMIT    = 5;
   localparam int unsigned REPEAT_TICKS   = 60;
   localparam int unsigned BLINK_TICKS    = 2;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned PHASES         = 10;
   localparam int unsigned PHASE_TICKS    = 75;

   logic clock = 1'b0;
   logic reset;

   ctc_req_if req_chan ();
   ctc_rsp_if rsp_chan ();
   ctc_csr_if csr_chan ();

   climate_tick_controller #(
      .ERROR_LIMIT  (ERROR_LIMIT),
      .REPEAT_TICKS (REPEAT_TICKS),
      .BLINK_TICKS  (BLINK_TICKS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always #2 clock = ~clock;

   // predicted results still owed by the block, oldest first
   ctc_pkg::rsp_type expected_ticks[$];
   int unsigned mismatches  = 0;
   int unsigned sent_ticks  = 0;
   int unsigned quiet_cycles = 0;
   bit steady_flow = 1'b0;

   // predictor copy of the configuration
   logic signed [7:0] heat_on_deg = '0, heat_off_deg = '0;
   logic signed [7:0] temp_alarm_low = '0, temp_alarm_high = '0;
   logic [7:0]  spray_on_pct = '0, spray_off_pct = '0;
   logic [7:0]  humi_alarm_low = '0, humi_alarm_high = '0;
   logic [14:0] mist_on_ticks = '0, mist_off_ticks = '0;
   logic [10:0] sunrise_min = '0, sunset_min = '0;
   logic        buzzer_on = 1'b0;

   // predictor copy of the controller state
   logic        heater_lit = 1'b0, spray_armed = 1'b0, mist_phase = 1'b0;
   logic [14:0] mist_count = ctc_pkg::SPRAY_IDLE;
   logic [7:0]  bad_reads = '0;
   logic        fault_latched = 1'b0, beeping = 1'b0, blink_level = 1'b1;
   logic [15:0] beep_age = '0, blink_age = '0;

   // register write into the predictor
   function automatic void apply_register(input ctc_pkg::csr_index_type idx,
                                          input logic [31:0] value);
      case (idx)
         ctc_pkg::CSR_TEMP_LIMITS: begin
            heat_on_deg     = value[7:0];
            heat_off_deg    = value[15:8];
            temp_alarm_low  = value[23:16];
            temp_alarm_high = value[31:24];
         end
         ctc_pkg::CSR_HUMI_LIMITS: begin
            spray_on_pct    = value[7:0];
            spray_off_pct   = value[15:8];
            humi_alarm_low  = value[23:16];
            humi_alarm_high = value[31:24];
         end
         ctc_pkg::CSR_SPRAY_ON_TICKS:  mist_on_ticks  = value[14:0];
         ctc_pkg::CSR_SPRAY_OFF_TICKS: mist_off_ticks = value[14:0];
         ctc_pkg::CSR_SUNRISE_MINUTES: sunrise_min    = value[10:0];
         ctc_pkg::CSR_SUNSET_MINUTES:  sunset_min     = value[10:0];
         ctc_pkg::CSR_BUZZER_ENABLE:   buzzer_on      = value[0];
         default: ;
      endcase
   endfunction

   // one control tick: update the predicted state and return the result
   function automatic ctc_pkg::rsp_type advance_tick(input ctc_pkg::req_type r);
      ctc_pkg::rsp_type  o;
      logic signed [7:0] deg;
      logic [7:0]        pct;
      logic              t_lo, t_hi, h_lo, h_hi, tank_dry, daylight, beep;
      logic [1:0]        level;
      int unsigned       tick_min;
      deg = r.temperature;
      pct = {1'b0, r.humidity};
      t_lo = 1'b0; t_hi = 1'b0; h_lo = 1'b0; h_hi = 1'b0;
      tank_dry = 1'b0; beep = 1'b0;

      // failed reads count up and saturate at the error limit
      if (!r.sensor_ok) begin
         bad_reads = bad_reads + 8'd1;
         if (bad_reads >= ERROR_LIMIT) begin
            bad_reads = 8'(ERROR_LIMIT);
            fault_latched = 1'b1;
         end
      end else begin
         fault_latched = 1'b0;
         bad_reads = '0;
      end

      // heater hysteresis, forced off on a bad read
      if (r.sensor_ok) begin
         if (deg <= heat_on_deg && !heater_lit)
            heater_lit = 1'b1;
         else if (deg >= heat_off_deg && heater_lit)
            heater_lit = 1'b0;
         t_lo = deg <= temp_alarm_low;
         t_hi = deg >= temp_alarm_high;
      end else begin
         heater_lit = 1'b0;
      end

      // tank level from the two pins
      if (r.water_low_pin && r.water_high_pin) begin
         level = ctc_pkg::TANK_FULL;
      end else if (r.water_low_pin) begin
         level = ctc_pkg::TANK_MID;
      end else begin
         level = ctc_pkg::TANK_DRY;
         tank_dry = 1'b1;
      end

      // sprayer enable and on/off duty cycle
      if (r.sensor_ok && !tank_dry) begin
         if (pct <= spray_on_pct && !spray_armed) begin
            spray_armed = 1'b1;
         end else if (pct >= spray_off_pct && spray_armed) begin
            spray_armed = 1'b0;
            mist_phase = 1'b0;
            mist_count = ctc_pkg::SPRAY_IDLE;
         end
         if (spray_armed) begin
            if (mist_count < ctc_pkg::SPRAY_IDLE) mist_count = mist_count + 15'd1;
            if (mist_phase) begin
               if (mist_count >= mist_on_ticks) begin
                  mist_phase = 1'b0;
                  mist_count = '0;
               end
            end else if (mist_count >= mist_off_ticks) begin
               mist_phase = 1'b1;
               mist_count = '0;
            end
         end
         h_lo = pct <= humi_alarm_low;
         h_hi = pct >= humi_alarm_high;
      end else begin
         spray_armed = 1'b0;
         mist_phase = 1'b0;
         mist_count = ctc_pkg::SPRAY_IDLE;
      end

      // daylight window, wrapping past midnight when sunset is earlier
      tick_min = r.clock_hour * ctc_pkg::MIN_PER_HOUR + r.clock_minute;
      if (sunset_min >= sunrise_min)
         daylight = (tick_min >= sunrise_min) && (tick_min < sunset_min);
      else
         daylight = !((tick_min >= sunset_min) && (tick_min < sunrise_min));

      // beep re-arm and blink while any alarm holds
      if (t_lo || t_hi || h_lo || h_hi || tank_dry || fault_latched) begin
         if (!beeping) begin
            beep = buzzer_on;
            beeping = 1'b1;
            beep_age = '0;
         end else begin
            beep_age = beep_age + 16'd1;
            if (beep_age >= REPEAT_TICKS) beeping = 1'b0;
         end
         blink_age = blink_age + 16'd1;
         if (blink_age >= BLINK_TICKS) begin
            blink_level = !blink_level;
            blink_age = '0;
         end
      end else begin
         beeping = 1'b0;
         beep_age = '0;
      end

      o.heater_on      = heater_lit;
      o.sprayer_on     = mist_phase;
      o.daylight_on    = daylight;
      o.tank_state     = level;
      o.temp_low_flag  = t_lo;
      o.temp_high_flag = t_hi;
      o.humi_low_flag  = h_lo;
      o.humi_high_flag = h_hi;
      o.sensor_fault   = fault_latched;
      o.beep_start     = beep;
      o.blink_phase    = blink_level;
      return o;
   endfunction

   function automatic ctc_pkg::req_type make_tick(input bit ok, input int deg, input int pct,
                                                  input bit half, input bit water,
                                                  input int hour, input int minute);
      ctc_pkg::req_type r;
      r.sensor_ok      = ok;
      r.temperature    = deg[7:0];
      r.humidity       = pct[6:0];
      r.water_high_pin = half;
      r.water_low_pin  = water;
      r.clock_hour     = hour[4:0];
      r.clock_minute   = minute[5:0];
      return r;
   endfunction

   function automatic logic [7:0] clamp_byte(input int v, input int lo, input int hi);
      int c;
      c = (v < lo) ? lo : (v > hi) ? hi : v;
      return c[7:0];
   endfunction

   function automatic void check_field(input string name, input logic [1:0] want,
                                       input logic [1:0] seen);
      if (seen !== want) begin
         $error("%s: expected %0d, got %0d", name, want, seen);
         mismatches++;
      end
   endfunction

   // send one request, idling first for a random number of cycles unless in a steady stretch
   task automatic send_tick(input ctc_pkg::req_type r);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.sensor_ok      <= r.sensor_ok;
      req_chan.temperature    <= r.temperature;
      req_chan.humidity       <= r.humidity;
      req_chan.water_high_pin <= r.water_high_pin;
      req_chan.water_low_pin  <= r.water_low_pin;
      req_chan.clock_hour     <= r.clock_hour;
      req_chan.clock_minute   <= r.clock_minute;
      @(posedge clock);
      while (!(req_chan.valid && req_chan.ready)) @(posedge clock);
      expected_ticks.push_back(advance_tick(r));
      sent_ticks++;
      // alternate between idling and stretches of back-to-back traffic
      if (sent_ticks % 40 == 0) steady_flow = ($urandom_range(0, 3) == 0);
   endtask

   // stop sending and wait until every owed result has arrived
   task automatic settle();
      req_chan.valid <= 1'b0;
      while (expected_ticks.size() != 0) @(posedge clock);
   endtask

   // csr valid stays high across back-to-back writes
   task automatic write_register(input ctc_pkg::csr_index_type idx, input logic [31:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!(csr_chan.valid && csr_chan.ready)) @(posedge clock);
      apply_register(idx, value);
   endtask

   task automatic configure(input logic [31:0] temp_set, input logic [31:0] humi_set,
                            input logic [14:0] on_ticks, input logic [14:0] off_ticks,
                            input logic [10:0] rise_min, input logic [10:0] set_min,
                            input logic buzz);
      settle();
      write_register(ctc_pkg::CSR_TEMP_LIMITS, temp_set);
      write_register(ctc_pkg::CSR_HUMI_LIMITS, humi_set);
      write_register(ctc_pkg::CSR_SPRAY_ON_TICKS, {17'd0, on_ticks});
      write_register(ctc_pkg::CSR_SPRAY_OFF_TICKS, {17'd0, off_ticks});
      write_register(ctc_pkg::CSR_SUNRISE_MINUTES, {21'd0, rise_min});
      write_register(ctc_pkg::CSR_SUNSET_MINUTES, {21'd0, set_min});
      write_register(ctc_pkg::CSR_BUZZER_ENABLE, {31'd0, buzz});
      csr_chan.valid <= 1'b0;
   endtask

   // limits left at their reset values
   task automatic test_reset_defaults();
      send_tick(make_tick(1, 0, 0, 1, 1, 0, 0));
      send_tick(make_tick(0, 5, 50, 1, 1, 12, 30));
   endtask

   // field extremes and out-of-range clock readings
   task automatic test_field_extremes();
      configure(32'h28F6_1914, 32'h5A0A_3C28, 15'd3, 15'd2, 11'd360, 11'd1200, 1'b1);
      send_tick(make_tick(1, -128, 0, 1, 1, 0, 0));
      send_tick(make_tick(1, 127, 100, 1, 1, 23, 59));
      send_tick(make_tick(1, 22, 127, 1, 1, 16, 32));
      send_tick(make_tick(1, 22, 50, 1, 1, 6, 0));
      send_tick(make_tick(1, 22, 50, 1, 1, 20, 0));
      send_tick(make_tick(1, 22, 50, 1, 1, 31, 63));
   endtask

   // consecutive bad reads up to a latched fault, then recovery
   task automatic test_sensor_fault();
      repeat (6) send_tick(make_tick(0, 10, 20, 1, 1, 9, 15));
      send_tick(make_tick(1, 10, 20, 1, 1, 9, 16));
   endtask

   // all four tank pin combinations
   task automatic test_tank_levels();
      send_tick(make_tick(1, 22, 30, 1, 1, 10, 0));
      send_tick(make_tick(1, 22, 30, 0, 1, 10, 1));
      send_tick(make_tick(1, 22, 30, 0, 0, 10, 2));
      send_tick(make_tick(1, 22, 30, 1, 0, 10, 3));
   endtask

   // daylight window that wraps past midnight
   task automatic test_wrapped_daylight();
      configure(32'h28F6_1914, 32'h5A0A_3C28, 15'd3, 15'd2, 11'd1200, 11'd360, 1'b1);
      send_tick(make_tick(1, 22, 50, 1, 1, 3, 0));
      send_tick(make_tick(1, 22, 50, 1, 1, 6, 0));
      send_tick(make_tick(1, 22, 50, 1, 1, 12, 0));
      send_tick(make_tick(1, 22, 50, 1, 1, 20, 0));
   endtask

   // drifting readings with fault bursts and tank episodes, over many register settings
   task automatic test_random_phases();
      int tc, hc, cur_temp, cur_humi, cur_min, bad_left, tank_left, tank_mode;
      logic [31:0] temp_set, humi_set;
      logic [14:0] on_ticks, off_ticks;
      logic [10:0] rise_min, set_min;
      ctc_pkg::req_type r;
      for (int phase = 0; phase < PHASES; phase++) begin
         tc = int'($urandom_range(0, 60)) - 10;
         hc = $urandom_range(15, 85);
         case (phase)
            0: configure('0, '0, '0, '0, '0, '0, 1'b0);
            1: configure('1, '1, 15'h7FFF, 15'h7FFF, 11'd2047, 11'd1500, 1'b1);
            2: configure(32'h807F_807F, 32'h6464_0000, 15'd1, 15'd0, 11'd0, 11'd1439, 1'b1);
            default: begin
               temp_set = {clamp_byte(tc + $urandom_range(5, 25), -128, 127),
                           clamp_byte(tc - $urandom_range(5, 25), -128, 127),
                           clamp_byte(tc + $urandom_range(0, 5), -128, 127),
                           clamp_byte(tc - $urandom_range(0, 5), -128, 127)};
               humi_set = {clamp_byte(hc + $urandom_range(5, 30), 0, 255),
                           clamp_byte(hc - $urandom_range(5, 30), 0, 255),
                           clamp_byte(hc + $urandom_range(0, 10), 0, 255),
                           clamp_byte(hc - $urandom_range(0, 10), 0, 255)};
               on_ticks  = ($urandom_range(0, 5) == 0) ? 15'($urandom_range(0, 32767))
                                                       : 15'($urandom_range(0, 8));
               off_ticks = ($urandom_range(0, 5) == 0) ? 15'($urandom_range(0, 32767))
                                                       : 15'($urandom_range(0, 8));
               rise_min  = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2047))
                                                       : 11'($urandom_range(0, 1439));
               set_min   = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2047))
                                                       : 11'($urandom_range(0, 1439));
               configure(temp_set, humi_set, on_ticks, off_ticks, rise_min, set_min,
                         1'($urandom_range(0, 1)));
            end
         endcase
         cur_temp = tc;
         cur_humi = hc;
         cur_min = $urandom_range(0, 1439);
         bad_left = 0;
         tank_left = 0;
         tank_mode = 0;
         repeat (PHASE_TICKS) begin
            // bad reads arrive in bursts so the error counter can saturate
            if (bad_left > 0) bad_left--;
            else if ($urandom_range(0, 24) == 0) bad_left = $urandom_range(1, 8);
            // tank episodes, some long enough for the beep to re-arm
            if (tank_left > 0) begin
               tank_left--;
            end else begin
               tank_left = $urandom_range(10, 90);
               tank_mode = $urandom_range(0, 4);
            end
            cur_temp += int'($urandom_range(0, 6)) - 3;
            if ($urandom_range(0, 30) == 0) cur_temp = int'($urandom_range(0, 255)) - 128;
            if (cur_temp > 127) cur_temp = 127;
            if (cur_temp < -128) cur_temp = -128;
            cur_humi += int'($urandom_range(0, 6)) - 3;
            if ($urandom_range(0, 30) == 0) cur_humi = $urandom_range(0, 127);
            if (cur_humi > 127) cur_humi = 127;
            if (cur_humi < 0) cur_humi = 0;
            cur_min = (cur_min + $urandom_range(0, 40)) % 1440;
            case (tank_mode)
               0, 1: r = make_tick(bad_left == 0, cur_temp, cur_humi, 1, 1,
                                   cur_min / 60, cur_min % 60);
               2: r = make_tick(bad_left == 0, cur_temp, cur_humi, 0, 1,
                                cur_min / 60, cur_min % 60);
               3: r = make_tick(bad_left == 0, cur_temp, cur_humi, 0, 0,
                                cur_min / 60, cur_min % 60);
               default: r = make_tick(bad_left == 0, cur_temp, cur_humi, 1, 0,
                                      cur_min / 60, cur_min % 60);
            endcase
            // out-of-range clock readings now and then
            if ($urandom_range(0, 39) == 0) begin
               r.clock_hour = 5'($urandom_range(0, 31));
               r.clock_minute = 6'($urandom_range(0, 63));
            end
            // noise: every field drawn at random
            if ($urandom_range(0, 11) == 0)
               r = make_tick(1'($urandom_range(0, 1)), int'($urandom_range(0, 255)) - 128,
                             int'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                             1'($urandom_range(0, 1)), int'($urandom_range(0, 31)),
                             int'($urandom_range(0, 63)));
            send_tick(r);
         end
      end
   endtask

   // result side: random stall before taking each result, unless in a steady stretch
   initial begin : result_sink
      int stall;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 13);
         if (stall != 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_chan.valid && rsp_chan.ready)) @(posedge clock);
      end
   end

   // compare each accepted result with the oldest prediction
   always @(posedge clock) begin : result_check
      ctc_pkg::rsp_type want;
      if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_ticks.size() == 0) begin
            $error("result with no request outstanding");
            mismatches++;
         end else begin
            want = expected_ticks.pop_front();
            check_field("heater_on", 2'(want.heater_on), 2'(rsp_chan.heater_on));
            check_field("sprayer_on", 2'(want.sprayer_on), 2'(rsp_chan.sprayer_on));
            check_field("daylight_on", 2'(want.daylight_on), 2'(rsp_chan.daylight_on));
            check_field("tank_state", want.tank_state, rsp_chan.tank_state);
            check_field("temp_low_flag", 2'(want.temp_low_flag),
                        2'(rsp_chan.temp_low_flag));
            check_field("temp_high_flag", 2'(want.temp_high_flag),
                        2'(rsp_chan.temp_high_flag));
            check_field("humi_low_flag", 2'(want.humi_low_flag),
                        2'(rsp_chan.humi_low_flag));
            check_field("humi_high_flag", 2'(want.humi_high_flag),
                        2'(rsp_chan.humi_high_flag));
            check_field("sensor_fault", 2'(want.sensor_fault), 2'(rsp_chan.sensor_fault));
            check_field("beep_start", 2'(want.beep_start), 2'(rsp_chan.beep_start));
            check_field("blink_phase", 2'(want.blink_phase), 2'(rsp_chan.blink_phase));
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : run
      reset                   <= 1'b1;
      req_chan.valid          <= 1'b0;
      req_chan.sensor_ok      <= 1'b0;
      req_chan.temperature    <= '0;
      req_chan.humidity       <= '0;
      req_chan.water_high_pin <= 1'b0;
      req_chan.water_low_pin  <= 1'b0;
      req_chan.clock_hour     <= '0;
      req_chan.clock_minute   <= '0;
      csr_chan.valid          <= 1'b0;
      csr_chan.index          <= '0;
      csr_chan.data           <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_field_extremes();
      test_sensor_fault();
      test_tank_levels();
      test_wrapped_daylight();
      test_random_phases();

      // drain, then give the pipeline time to show any stray result
      settle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_ticks.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
